[hw/rtl/esf_pkg.sv]
// Shared types and constants for the ECG sample filter chain.
// Holds the fixed coefficients, the sequencer step codes and the tap coefficient lookup.
// No dependencies.
`default_nettype none

package esf_pkg;

  // Field widths of the input and result words.
  localparam int SAMPLE_W = 12;
  localparam int OUT_W    = 12;

  // Internal data path: 32-bit saturated history values, 34-bit first multiplier operand.
  localparam int DATA_W = 32;
  localparam int OPA_W  = 34;

  // Coefficients are Q2.14.
  localparam int COEF_W     = 16;
  localparam int COEF_SHIFT = 14;
  localparam int ROUND_HALF = 1 << (COEF_SHIFT - 1);

  localparam logic signed [COEF_W-1:0] ALPHA_Q = 16'sd16310;

  // Notch biquad. The feedback coefficients are stored negated so that every term adds.
  localparam logic signed [COEF_W-1:0] NOTCH_B0  = 16'sd15155;
  localparam logic signed [COEF_W-1:0] NOTCH_B1  = -16'sd24248;
  localparam logic signed [COEF_W-1:0] NOTCH_B2  = 16'sd15155;
  localparam logic signed [COEF_W-1:0] NOTCH_NA1 = 16'sd24248;
  localparam logic signed [COEF_W-1:0] NOTCH_NA2 = -16'sd13926;

  // Low-pass biquad, feedback coefficients negated as above.
  localparam logic signed [COEF_W-1:0] LOWP_B0  = 16'sd3523;
  localparam logic signed [COEF_W-1:0] LOWP_B1  = 16'sd7045;
  localparam logic signed [COEF_W-1:0] LOWP_B2  = 16'sd3523;
  localparam logic signed [COEF_W-1:0] LOWP_NA1 = 16'sd5243;
  localparam logic signed [COEF_W-1:0] LOWP_NA2 = -16'sd2621;

  // Sequencer steps. Each product is issued in one step and accumulated in the next.
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_BASE_MUL     = 5'd0;
  localparam logic [STEP_W-1:0] STEP_BASE_ACC     = 5'd1;
  localparam logic [STEP_W-1:0] STEP_BASE_FIN     = 5'd2;
  localparam logic [STEP_W-1:0] STEP_NOTCH_MUL    = 5'd3;
  localparam logic [STEP_W-1:0] STEP_NOTCH_END    = 5'd7;
  localparam logic [STEP_W-1:0] STEP_NOTCH_ACC    = 5'd4;
  localparam logic [STEP_W-1:0] STEP_NOTCH_ACCEND = 5'd8;
  localparam logic [STEP_W-1:0] STEP_NOTCH_FIN    = 5'd9;
  localparam logic [STEP_W-1:0] STEP_LOWP_MUL     = 5'd10;
  localparam logic [STEP_W-1:0] STEP_LOWP_END     = 5'd14;
  localparam logic [STEP_W-1:0] STEP_LOWP_ACC     = 5'd11;
  localparam logic [STEP_W-1:0] STEP_LOWP_ACCEND  = 5'd15;
  localparam logic [STEP_W-1:0] STEP_LOWP_FIN     = 5'd16;
  localparam logic [STEP_W-1:0] STEP_AVG          = 5'd17;
  localparam logic [STEP_W-1:0] STEP_DIV_MUL      = 5'd18;
  localparam logic [STEP_W-1:0] STEP_OUT          = 5'd19;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  // Biquad taps in the order they are multiplied.
  typedef enum logic [2:0] {
    TAP_X  = 3'd0,
    TAP_X1 = 3'd1,
    TAP_X2 = 3'd2,
    TAP_Y1 = 3'd3,
    TAP_Y2 = 3'd4
  } tap_t;

  // Coefficient for one tap of either biquad.
  function automatic logic signed [COEF_W-1:0] biquad_coef(input logic is_lowp,
                                                          input tap_t tap);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (is_lowp) begin
      unique case (tap)
        TAP_X:   c = LOWP_B0;
        TAP_X1:  c = LOWP_B1;
        TAP_X2:  c = LOWP_B2;
        TAP_Y1:  c = LOWP_NA1;
        TAP_Y2:  c = LOWP_NA2;
        default: c = '0;
      endcase
    end else begin
      unique case (tap)
        TAP_X:   c = NOTCH_B0;
        TAP_X1:  c = NOTCH_B1;
        TAP_X2:  c = NOTCH_B2;
        TAP_Y1:  c = NOTCH_NA1;
        TAP_Y2:  c = NOTCH_NA2;
        default: c = '0;
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/esf_in_if.sv]
// Input channel of the ECG filter chain: valid, ready and one raw sample.
// Depends on esf_pkg for the sample width.
`default_nettype none

interface esf_in_if;
  import esf_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

[hw/rtl/esf_out_if.sv]
// Result channel of the ECG filter chain: valid, ready and one filtered sample.
// Depends on esf_pkg for the result width.
`default_nettype none

interface esf_out_if;
  import esf_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

`default_nettype wire

[hw/rtl/esf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module esf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[hw/rtl/ecg_sample_filter_chain_core.sv]
// ECG sample filter chain: baseline high-pass, 50 Hz notch, 100 Hz low-pass, moving average.
// Depends on esf_pkg, esf_in_if, esf_out_if and esf_ram.
//
// Each 12-bit converter sample word gives one filtered word. All arithmetic runs on a
// single shared signed multiplier with a registered product and one accumulator, stepped
// by a small sequencer: one product for the baseline high-pass, five for each biquad and
// one reciprocal product for the division of the window sum by WINDOW, with a rounding
// and saturation step after each filter and one step that updates the averaging window.
// A word passes through all these steps from acceptance to the result register, and the
// input is ready again in the cycle after that register loads. The input is not ready
// while a word is in work. A finished result waits in the output register; the next
// word is accepted meanwhile and only its last step waits for the register to free. The
// window lives in a RAM with a valid bit per entry, so it reads as zero after reset
// without any clearing pass.
`default_nettype none

module ecg_sample_filter_chain_core #(
  parameter int WINDOW     = 8,
  parameter int FULL_SCALE = 4095,
  parameter int FRAC_BITS  = 8
) (
  input logic clk,
  input logic rst_n,
  esf_in_if.sink    in_ch,
  esf_out_if.source out_ch
);
  import esf_pkg::*;

  localparam int     AW       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int     IV_W     = $clog2(FULL_SCALE + 1);
  localparam longint TOT_MAX  = longint'(WINDOW) * longint'(FULL_SCALE);
  localparam int     TOT_W    = $clog2(TOT_MAX + 1);
  localparam int     DIV_L    = $clog2(WINDOW);
  localparam int     DIV_S    = TOT_W + DIV_L;
  localparam longint DIV_M    = ((longint'(1) << DIV_S) + WINDOW - 1) / WINDOW;
  localparam int     OPB_W    = (TOT_W + 3 > COEF_W) ? TOT_W + 3 : COEF_W;
  localparam int     MUL_W    = OPA_W + OPB_W;
  localparam int     ACC_W    = MUL_W + 2;
  localparam longint OFS      = (longint'(FULL_SCALE) << FRAC_BITS) >> 1;
  localparam logic [AW-1:0] POS_LAST = AW'(WINDOW - 1);

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

  // Saturate an accumulator-wide value to the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[DATA_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  state_t                   state_r, state_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic                     in_acc;
  logic                     out_free;

  logic [SAMPLE_W-1:0]      samp_r;
  logic [SAMPLE_W-1:0]      prev_in_r;
  logic signed [DATA_W-1:0] prev_out_r;
  logic signed [DATA_W-1:0] v_r;
  logic signed [DATA_W-1:0] nx0_r, nx1_r, ny0_r, ny1_r;
  logic signed [DATA_W-1:0] lx0_r, lx1_r, ly0_r, ly1_r;
  logic [AW-1:0]            pos_r, pos_nxt;
  logic [WINDOW-1:0]        valid_r;
  logic [TOT_W-1:0]         total_r;
  logic                     out_valid_r;
  logic [OUT_W-1:0]         out_filt_r;

  logic signed [SAMPLE_W:0]  delta;
  logic signed [OPA_W-1:0]   base_d;
  logic signed [OPA_W-1:0]   mul_a;
  logic signed [OPB_W-1:0]   mul_b;
  logic signed [MUL_W-1:0]   mul_full;
  logic                      mul_en;
  logic signed [ACC_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      acc_ld, acc_add;
  tap_t                      notch_tap, lowp_tap;
  logic signed [DATA_W-1:0]  notch_val, lowp_val;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [DATA_W-1:0]  y_sat;
  logic signed [DATA_W-1:0]  hp_off;
  logic [DATA_W-1:0]         v_int;
  logic [IV_W-1:0]           iv;
  logic [IV_W-1:0]           rd_data;
  logic [IV_W-1:0]           old_val;
  logic [TOT_W-1:0]          total_upd;
  logic                      run;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign run      = (state_r == ST_RUN);

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.filtered = out_filt_r;

  // Next write position in the averaging window.
  assign pos_nxt = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;

  // Baseline difference term: previous output plus the shifted sample step.
  assign delta  = $signed({1'b0, samp_r}) - $signed({1'b0, prev_in_r});
  assign base_d = OPA_W'(prev_out_r) + (OPA_W'(delta) <<< FRAC_BITS);

  assign notch_tap = tap_t'(3'(step_r - STEP_NOTCH_MUL));
  assign lowp_tap  = tap_t'(3'(step_r - STEP_LOWP_MUL));

  // History value for the tap being multiplied in each biquad.
  always_comb begin
    case (notch_tap)
      TAP_X:   notch_val = v_r;
      TAP_X1:  notch_val = nx0_r;
      TAP_X2:  notch_val = nx1_r;
      TAP_Y1:  notch_val = ny0_r;
      TAP_Y2:  notch_val = ny1_r;
      default: notch_val = v_r;
    endcase
    case (lowp_tap)
      TAP_X:   lowp_val = v_r;
      TAP_X1:  lowp_val = lx0_r;
      TAP_X2:  lowp_val = lx1_r;
      TAP_Y1:  lowp_val = ly0_r;
      TAP_Y2:  lowp_val = ly1_r;
      default: lowp_val = v_r;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    if (run) begin
      if (step_r == STEP_BASE_MUL) begin
        mul_en = 1'b1;
        mul_a  = base_d;
        mul_b  = OPB_W'(ALPHA_Q);
      end else if (step_r >= STEP_NOTCH_MUL && step_r <= STEP_NOTCH_END) begin
        mul_en = 1'b1;
        mul_a  = OPA_W'(notch_val);
        mul_b  = OPB_W'(biquad_coef(1'b0, notch_tap));
      end else if (step_r >= STEP_LOWP_MUL && step_r <= STEP_LOWP_END) begin
        mul_en = 1'b1;
        mul_a  = OPA_W'(lowp_val);
        mul_b  = OPB_W'(biquad_coef(1'b1, lowp_tap));
      end else if (step_r == STEP_DIV_MUL) begin
        mul_en = 1'b1;
        mul_a  = OPA_W'(total_r);
        mul_b  = OPB_W'(DIV_M);
      end
    end
  end

  assign mul_full = mul_a * mul_b;

  // Accumulator control: the first product of a filter loads, the rest add.
  assign acc_ld  = run && (step_r == STEP_BASE_ACC || step_r == STEP_NOTCH_ACC ||
                           step_r == STEP_LOWP_ACC);
  assign acc_add = run && ((step_r > STEP_NOTCH_ACC && step_r <= STEP_NOTCH_ACCEND) ||
                           (step_r > STEP_LOWP_ACC && step_r <= STEP_LOWP_ACCEND));

  // Scale by 2^-14 with ties upward, then saturate; the baseline adds mid-scale after.
  assign acc_rnd = (acc_r + ACC_W'(ROUND_HALF)) >>> COEF_SHIFT;
  assign y_sat   = sat32(acc_rnd);
  assign hp_off  = sat32(ACC_W'(y_sat) + ACC_W'(OFS));

  // Integer part of the low-pass output, clamped to the converter range.
  assign v_int = DATA_W'(unsigned'(v_r)) >> FRAC_BITS;
  always_comb begin
    if (v_r[DATA_W-1]) begin
      iv = '0;
    end else if (v_int > DATA_W'(FULL_SCALE)) begin
      iv = IV_W'(FULL_SCALE);
    end else begin
      iv = v_int[IV_W-1:0];
    end
  end

  // Entry leaving the window reads as zero until it has been written once.
  assign old_val   = valid_r[pos_nxt] ? rd_data : '0;
  assign total_upd = total_r - TOT_W'(old_val) + TOT_W'(iv);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_RUN;
          step_nxt  = STEP_BASE_MUL;
        end
      end
      ST_RUN: begin
        if (step_r == STEP_OUT) begin
          if (out_free) begin
            state_nxt = ST_IDLE;
            step_nxt  = '0;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  // Control and filter state, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      prev_in_r   <= '0;
      prev_out_r  <= '0;
      nx0_r       <= '0;
      nx1_r       <= '0;
      ny0_r       <= '0;
      ny1_r       <= '0;
      lx0_r       <= '0;
      lx1_r       <= '0;
      ly0_r       <= '0;
      ly1_r       <= '0;
      pos_r       <= '0;
      valid_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (run && step_r == STEP_BASE_FIN) begin
        prev_in_r  <= samp_r;
        prev_out_r <= y_sat;
      end
      if (run && step_r == STEP_NOTCH_FIN) begin
        nx1_r <= nx0_r;
        nx0_r <= v_r;
        ny1_r <= ny0_r;
        ny0_r <= y_sat;
      end
      if (run && step_r == STEP_LOWP_FIN) begin
        lx1_r <= lx0_r;
        lx0_r <= v_r;
        ly1_r <= ly0_r;
        ly0_r <= y_sat;
      end
      if (run && step_r == STEP_AVG) begin
        pos_r            <= pos_nxt;
        valid_r[pos_nxt] <= 1'b1;
        total_r          <= total_upd;
      end
      if (run && step_r == STEP_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Data path registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      samp_r <= in_ch.sample;
    end
    if (mul_en) begin
      prod_r <= ACC_W'(mul_full);
    end
    if (acc_ld) begin
      acc_r <= prod_r;
    end else if (acc_add) begin
      acc_r <= acc_r + prod_r;
    end
    if (run && step_r == STEP_BASE_FIN) begin
      v_r <= hp_off;
    end else if (run && (step_r == STEP_NOTCH_FIN || step_r == STEP_LOWP_FIN)) begin
      v_r <= y_sat;
    end
    if (run && step_r == STEP_OUT && out_free) begin
      out_filt_r <= prod_r[DIV_S +: OUT_W];
    end
  end

  // Averaging window store; the leaving entry is read as the word is accepted.
  esf_ram #(
    .WIDTH (IV_W),
    .DEPTH (WINDOW)
  ) u_window (
    .clk     (clk),
    .wr_en   (run && step_r == STEP_AVG),
    .wr_addr (pos_nxt),
    .wr_data (iv),
    .rd_en   (in_acc),
    .rd_addr (pos_nxt),
    .rd_data (rd_data)
  );

  // An accepted word always starts the sequence at its first step.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_RUN) && (step_r == STEP_BASE_MUL))
    else $error("sequence did not start after an accepted word");

  // A result appears only from the final step of the sequence.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(run && step_r == STEP_OUT))
    else $error("result register loaded outside the final step");

  // The window sum never exceeds a full window of full-scale values.
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TOT_W'(TOT_MAX))
    else $error("window sum out of range");

  // The window position only moves in the update step.
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !(run && step_r == STEP_AVG) |=> $stable(pos_r))
    else $error("window position moved outside the update step");

endmodule

`default_nettype wire
